@@ rtl/cql_pkg.sv @@
// ----------------------------------------------------------------------------
// cql_pkg
// shared types, codes and constants of the capacity quota ledger
// ----------------------------------------------------------------------------
package cql_pkg;

	localparam int KIND_COUNT_DEF = 4;
	localparam int COUNT_BITS_DEF = 32;
	localparam int REG_COUNT = 4;
	localparam int FIELD_BITS = 32;
	localparam int KIND_BITS = 3;
	localparam int ADDR_BITS = 4;

	typedef enum logic [1:0] {
		ACT_RESERVE = 2'd0,
		ACT_COMMIT  = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_INVALID = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_CORRUPT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OC_EXHAUSTED   = 3'd0,
		OC_RESERVED    = 3'd1,
		OC_BLOCK_SET   = 3'd2,
		OC_ALREADY_BLK = 3'd3,
		OC_COMMITTED   = 3'd4,
		OC_RELEASED    = 3'd5,
		OC_REL_EXHAUST = 3'd6,
		OC_REL_UNBLOCK = 3'd7
	} outcome_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_EXEC = 2'd1,
		FSM_HOLD = 2'd2
	} fsm_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} cql_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;
	} cql_sts_t;

endpackage

@@ rtl/cql_ctrl.sv @@
// ----------------------------------------------------------------------------
// cql_ctrl
// request sequencer: capture, execute, hold result until taken
// ----------------------------------------------------------------------------
module cql_ctrl
	import cql_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     out_fire,
	input  cql_sts_t sts,
	output cql_cmd_t cmd,
	output logic     in_ready,
	output logic     out_valid
);

	fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: if (in_fire) state_d = FSM_EXEC;
			FSM_EXEC: if (sts.done) state_d = FSM_HOLD;
			FSM_HOLD: if (out_fire) state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_fire;
			end
			FSM_EXEC: cmd.exec = 1'b1;
			FSM_HOLD: out_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

@@ rtl/cql_dp.sv @@
// ----------------------------------------------------------------------------
// cql_dp
// ledger entries, checks and update
// ----------------------------------------------------------------------------
module cql_dp
	import cql_pkg::*;
#(
	parameter int KIND_COUNT = KIND_COUNT_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cql_cmd_t              cmd,
	output cql_sts_t              sts,
	input  logic [1:0]            action,
	input  logic [KIND_BITS-1:0]  kind,
	input  logic [FIELD_BITS-1:0] amount,
	input  logic [FIELD_BITS-1:0] give_used,
	input  logic [FIELD_BITS-1:0] give_resv,
	input  logic                  reopen,
	input  logic [FIELD_BITS-1:0] limit_reg [REG_COUNT],
	output logic [1:0]            status,
	output logic [2:0]            outcome,
	output logic [FIELD_BITS-1:0] used_now,
	output logic [FIELD_BITS-1:0] reserved_now,
	output logic [FIELD_BITS-1:0] peak_now,
	output logic [FIELD_BITS-1:0] epoch_now,
	output logic                  blocked_now,
	output logic                  exhausted_now,
	output logic                  exhausted_newly_set
);

	localparam int CB = COUNT_BITS;
	localparam int KB = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;
	localparam int WB = (CB > FIELD_BITS) ? CB : FIELD_BITS;
	localparam logic [CB-1:0] ALL_ONES = '1;

	logic [CB-1:0] used_q [KIND_COUNT];
	logic [CB-1:0] resv_q [KIND_COUNT];
	logic [CB-1:0] hwm_q  [KIND_COUNT];
	logic [CB-1:0] epoch_q[KIND_COUNT];
	logic [KIND_COUNT-1:0] blk_q, exh_q;

	// captured request
	logic [1:0]            act_q;
	logic [KIND_BITS-1:0]  kind_q;
	logic [FIELD_BITS-1:0] amt_q, ur_q, rr_q;
	logic                  ro_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			kind_q <= kind;
			amt_q  <= amount;
			ur_q   <= give_used;
			rr_q   <= give_resv;
			ro_q   <= reopen;
		end
	end

	logic [KB-1:0] k;
	logic kind_ok, shape_ok;
	logic [CB-1:0] u, r, h, e, lim, tot, u_n, r_n, h_n, e_n, avail;
	logic [CB:0] sum;
	logic [WB-1:0] amt_w, ur_w, rr_w, lim_w;
	logic b, x, b_n, x_n, ok, wr, newly;
	logic [1:0] st;
	logic [2:0] oc;

	always_comb begin
		kind_ok = ({{(32-KIND_BITS){1'b0}}, kind_q} < 32'(KIND_COUNT));
		k = KB'(kind_q);
		u = used_q[k]; r = resv_q[k]; h = hwm_q[k]; e = epoch_q[k];
		b = blk_q[k]; x = exh_q[k];
		amt_w = WB'(amt_q); ur_w = WB'(ur_q); rr_w = WB'(rr_q);
		// kinds without a register see limit 0
		lim_w = ({{(32-KIND_BITS){1'b0}}, kind_q} < 32'(REG_COUNT)) ?
			WB'(limit_reg[kind_q[1:0]]) : '0;
		lim = (lim_w > WB'(ALL_ONES)) ? ALL_ONES : CB'(lim_w);
		case (act_q)
			ACT_RESERVE, ACT_COMMIT:
				shape_ok = (amt_q != '0) && (ur_q == '0) && (rr_q == '0) && !ro_q;
			ACT_RELEASE: shape_ok = (amt_q == '0) && ((ur_q != '0) || (rr_q != '0));
			default: shape_ok = 1'b0;
		endcase
		sum = {1'b0, u} + {1'b0, r};
		tot = sum[CB-1:0];
		ok = (e != '0) && !sum[CB] && (tot <= lim) && (h >= tot) && (h <= lim)
			&& (!x || ((e == ALL_ONES) && !b));
		avail = lim - tot;
		u_n = u; r_n = r; h_n = h; e_n = e; b_n = b; x_n = x;
		newly = 1'b0; oc = OC_EXHAUSTED; st = ST_OK;
		if (!shape_ok || !kind_ok) st = ST_INVALID;
		else if (!ok) st = ST_CORRUPT;
		else begin
			case (act_q)
				ACT_RESERVE: begin
					if (x) oc = OC_EXHAUSTED;
					else if (amt_w <= WB'(avail)) begin
						r_n = r + CB'(amt_w);
						if (h < tot + CB'(amt_w)) h_n = tot + CB'(amt_w);
						oc = OC_RESERVED;
					end else if (!b) begin
						b_n = 1'b1; oc = OC_BLOCK_SET;
					end else oc = OC_ALREADY_BLK;
				end
				ACT_COMMIT: begin
					if (amt_w > WB'(r)) st = ST_CORRUPT;
					else begin
						r_n = r - CB'(amt_w); u_n = u + CB'(amt_w); oc = OC_COMMITTED;
					end
				end
				default: begin
					if ((ur_w > WB'(u)) || (rr_w > WB'(r))) st = ST_CORRUPT;
					else begin
						u_n = u - CB'(ur_w); r_n = r - CB'(rr_w); oc = OC_RELEASED;
						if (b && ro_q) begin
							b_n = 1'b0;
							if (e == ALL_ONES) begin
								x_n = 1'b1; newly = 1'b1; oc = OC_REL_EXHAUST;
							end else begin
								e_n = e + 1'b1; oc = OC_REL_UNBLOCK;
							end
						end
					end
				end
			endcase
		end
		wr = cmd.exec && (st == ST_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KIND_COUNT; i++) begin
				used_q[i] <= '0; resv_q[i] <= '0; hwm_q[i] <= '0;
				epoch_q[i] <= CB'(1);
			end
			blk_q <= '0; exh_q <= '0;
		end else if (wr) begin
			used_q[k] <= u_n; resv_q[k] <= r_n; hwm_q[k] <= h_n;
			epoch_q[k] <= e_n; blk_q[k] <= b_n; exh_q[k] <= x_n;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status <= st;
			if (st == ST_OK) begin
				outcome <= oc;
				used_now <= FIELD_BITS'(WB'(u_n));
				reserved_now <= FIELD_BITS'(WB'(r_n));
				peak_now <= FIELD_BITS'(WB'(h_n));
				epoch_now <= FIELD_BITS'(WB'(e_n));
				blocked_now <= b_n; exhausted_now <= x_n;
				exhausted_newly_set <= newly;
			end else begin
				outcome <= '0; used_now <= '0; reserved_now <= '0;
				peak_now <= '0; epoch_now <= '0;
				blocked_now <= 1'b0; exhausted_now <= 1'b0;
				exhausted_newly_set <= 1'b0;
			end
		end
	end

	assign sts.done = cmd.exec;

endmodule

@@ rtl/capacity_quota_ledger_unit.sv @@
// ----------------------------------------------------------------------------
// capacity_quota_ledger_unit
// per-kind quota ledger with reserve, commit and release requests
// ----------------------------------------------------------------------------
// each request is captured, then executed, and its registered result is held until taken
// a new request is accepted only after the previous result has been taken (capture, execute, deliver)
// the execute state reads, checks and writes back one ledger entry
// reset: asynchronous, clears all entries (epoch 1) and limits to zero
module capacity_quota_ledger_unit
	import cql_pkg::*;
#(
	parameter int KIND_COUNT = KIND_COUNT_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// apb configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// request stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [1:0] action, [4:2] kind, [36:5] amount, [68:37] used units back,
	// [100:69] reserved units back, [101] reopen, [103:102] zero
	input  logic [103:0]         s_tdata,
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [1:0] status, [4:2] outcome, [36:5] used_now, [68:37] reserved_now,
	// [100:69] high-water mark, [132:101] epoch_now, [133] blocked_now,
	// [134] exhausted_now, [135] exhausted_newly_set
	output logic [135:0]         m_tdata
);

	// limit registers
	logic [FIELD_BITS-1:0] limit_q [REG_COUNT];
	logic [1:0] ridx;
	assign ridx = paddr[3:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) limit_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			limit_q[ridx] <= pwdata;
		end
	end
	assign prdata = limit_q[ridx];

	cql_cmd_t cmd;
	cql_sts_t sts;
	logic in_fire, out_fire;
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	cql_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_fire, .sts, .cmd,
		.in_ready(s_tready), .out_valid(m_tvalid)
	);

	cql_dp #(.KIND_COUNT(KIND_COUNT), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.action(s_tdata[1:0]), .kind(s_tdata[4:2]), .amount(s_tdata[36:5]),
		.give_used(s_tdata[68:37]), .give_resv(s_tdata[100:69]),
		.reopen(s_tdata[101]), .limit_reg(limit_q),
		.status(m_tdata[1:0]), .outcome(m_tdata[4:2]), .used_now(m_tdata[36:5]),
		.reserved_now(m_tdata[68:37]), .peak_now(m_tdata[100:69]),
		.epoch_now(m_tdata[132:101]), .blocked_now(m_tdata[133]),
		.exhausted_now(m_tdata[134]), .exhausted_newly_set(m_tdata[135])
	);

endmodule

@@ rtl/cql_checker.sv @@
// ----------------------------------------------------------------------------
// cql_checker
// port-level checks of the ledger unit
// ----------------------------------------------------------------------------
module cql_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [135:0] m_tdata
);

	// no new request while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("ready while result pending");

	// error results carry zero payload
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] != 2'd0) |-> (m_tdata[135:2] == '0))
		else $error("error result with payload");

	// status code 3 never appears
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'd3)) else $error("bad status");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped");

endmodule

bind capacity_quota_ledger_unit cql_checker u_chk (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

@@ verif/capacity_quota_ledger_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capacity_quota_ledger_unit_tb
// drives reserve, commit and release requests through the request stream,
// predicts every ledger entry in a local copy and checks each result transfer
// field by field; limits are reprogrammed over apb between phases
// ----------------------------------------------------------------------------
module capacity_quota_ledger_unit_tb;
	import cql_pkg::*;

	localparam int KINDS = 4;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic        reopen;
		logic [31:0] rel_reserved;
		logic [31:0] rel_used;
		logic [31:0] amount;
		logic [2:0]  kind;
		action_t     action;
	} request_t;

	typedef struct packed {
		logic        newly;
		logic        exhausted;
		logic        blocked;
		logic [31:0] epoch;
		logic [31:0] peak;
		logic [31:0] reserved;
		logic [31:0] used;
		outcome_t    outcome;
		status_t     status;
	} ledger_result_t;

	// one row of the directed table; check_row set when want is typed in
	typedef struct {
		request_t       req;
		logic           check_row;
		ledger_result_t want;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [103:0]         s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [135:0]         m_tdata;

	// predicted ledger and limits
	logic [31:0] lim_q[KINDS];
	logic [31:0] used_q[KINDS];
	logic [31:0] resv_q[KINDS];
	logic [31:0] hwm_q[KINDS];
	logic [31:0] epoch_q[KINDS];
	logic        blk_q[KINDS];
	logic        exh_q[KINDS];

	ledger_result_t pending_results[$];
	int  fail_count = 0;
	int  cycle_count = 0;
	bit  hold_long = 1'b0;
	bit  stim_done = 1'b0;

	capacity_quota_ledger_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("capacity_quota_ledger_unit regression: fail");
			$finish;
		end
	end

	// ledger predictor: works out one result and updates the local entry
	function automatic ledger_result_t ledger_apply(request_t r);
		ledger_result_t res;
		logic [32:0] total;
		logic [31:0] room;
		int k;
		bit shape;
		res = '0;
		res.status = ST_OK;
		case (r.action)
			ACT_RESERVE, ACT_COMMIT: shape = r.amount != 0 && r.rel_used == 0 &&
				r.rel_reserved == 0 && !r.reopen;
			ACT_RELEASE: shape = r.amount == 0 && (r.rel_used != 0 || r.rel_reserved != 0);
			default: shape = 0;
		endcase
		if (!shape || r.kind >= KINDS) begin
			res.status = ST_INVALID;
			return res;
		end
		k = r.kind;
		total = {1'b0, used_q[k]} + {1'b0, resv_q[k]};
		// entry checks come before the action
		if (epoch_q[k] == 0 || total[32] || total[31:0] > lim_q[k] ||
				hwm_q[k] < total[31:0] || hwm_q[k] > lim_q[k] ||
				(exh_q[k] && !(epoch_q[k] == ALL_ONES && !blk_q[k]))) begin
			res.status = ST_CORRUPT;
			return res;
		end
		case (r.action)
			ACT_RESERVE: begin
				room = lim_q[k] - total[31:0];
				if (exh_q[k]) begin
					res.outcome = OC_EXHAUSTED;
				end else if (r.amount <= room) begin
					resv_q[k] = resv_q[k] + r.amount;
					if (hwm_q[k] < total[31:0] + r.amount)
						hwm_q[k] = total[31:0] + r.amount;
					res.outcome = OC_RESERVED;
				end else if (!blk_q[k]) begin
					blk_q[k] = 1'b1;
					res.outcome = OC_BLOCK_SET;
				end else begin
					res.outcome = OC_ALREADY_BLK;
				end
			end
			ACT_COMMIT: begin
				if (r.amount > resv_q[k]) begin
					res.status = ST_CORRUPT;
					return res;
				end
				resv_q[k] = resv_q[k] - r.amount;
				used_q[k] = used_q[k] + r.amount;
				res.outcome = OC_COMMITTED;
			end
			default: begin
				if (r.rel_used > used_q[k] || r.rel_reserved > resv_q[k]) begin
					res.status = ST_CORRUPT;
					return res;
				end
				used_q[k] = used_q[k] - r.rel_used;
				resv_q[k] = resv_q[k] - r.rel_reserved;
				res.outcome = OC_RELEASED;
				if (blk_q[k] && r.reopen) begin
					blk_q[k] = 1'b0;
					if (epoch_q[k] == ALL_ONES) begin
						exh_q[k] = 1'b1;
						res.newly = 1'b1;
						res.outcome = OC_REL_EXHAUST;
					end else begin
						epoch_q[k] = epoch_q[k] + 1;
						res.outcome = OC_REL_UNBLOCK;
					end
				end
			end
		endcase
		res.used = used_q[k];
		res.reserved = resv_q[k];
		res.peak = hwm_q[k];
		res.epoch = epoch_q[k];
		res.blocked = blk_q[k];
		res.exhausted = exh_q[k];
		return res;
	endfunction

	// result checker: compares every result transfer with the oldest prediction
	always @(posedge clk) begin
		ledger_result_t got;
		ledger_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got = ledger_result_t'(m_tdata);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transfer, actual %h", $time, m_tdata);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (got.status != exp_r.status || got.outcome != exp_r.outcome ||
						got.used != exp_r.used || got.reserved != exp_r.reserved ||
						got.peak != exp_r.peak || got.epoch != exp_r.epoch ||
						got.blocked != exp_r.blocked || got.exhausted != exp_r.exhausted ||
						got.newly != exp_r.newly) begin
					$display("%0t: result mismatch, expected %h, actual %h",
						$time, exp_r, got);
					fail_count++;
				end
			end
		end
	end

	// receiver: random stall per result, or a long hold-off on request
	always @(posedge clk) begin
		int wait_cycles;
		if (arst_n) begin
			if (hold_long) begin
				m_tready <= 1'b0;
				repeat (60) @(posedge clk);
				hold_long = 1'b0;
			end
			wait_cycles = stim_done ? 0 : ($urandom_range(0, 3) == 0 ? 0 :
				$urandom_range(0, 14));
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic apb_write(int idx, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_BITS'(4 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		lim_q[idx] = value;
		@(posedge clk);
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one request transfer; the prediction is queued at the accepting edge
	task automatic send_request(request_t r, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, r};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(ledger_apply(r));
	endtask

	function automatic request_t make_req(action_t a, int k, logic [31:0] amt,
			logic [31:0] ru, logic [31:0] rr, logic ro);
		request_t r;
		r.action = a;
		r.kind = 3'(k);
		r.amount = amt;
		r.rel_used = ru;
		r.rel_reserved = rr;
		r.reopen = ro;
		return r;
	endfunction

	function automatic ledger_result_t err_result(status_t st);
		ledger_result_t e;
		e = '0;
		e.status = st;
		return e;
	endfunction

	// mostly well-formed requests; reserve amounts are scaled to the kind's limit
	function automatic request_t random_request();
		request_t r;
		int k;
		int pick;
		logic [31:0] span;
		k = $urandom_range(0, 3);
		pick = $urandom_range(0, 99);
		span = lim_q[k] == 0 ? 32'd4 : lim_q[k];
		r = make_req(ACT_RESERVE, k, 0, 0, 0, 1'b0);
		if (pick < 35) begin
			r.amount = $urandom_range(0, 5) == 0 ? $urandom() :
				1 + ($urandom() % ((span >> 2) + 1));
		end else if (pick < 55) begin
			r.action = ACT_COMMIT;
			r.amount = 1 + ($urandom() % ((resv_q[k] == 0 ? 32'd2 : resv_q[k]) + 1));
		end else if (pick < 85) begin
			r.action = ACT_RELEASE;
			r.rel_used = used_q[k] == 0 ? 0 : $urandom() % (used_q[k] + 1);
			r.rel_reserved = resv_q[k] == 0 ? 0 : $urandom() % (resv_q[k] + 1);
			if (r.rel_used == 0 && r.rel_reserved == 0)
				r.rel_reserved = $urandom_range(0, 1);
			r.reopen = $urandom_range(0, 3) != 0;
		end else begin
			// noise: any field pattern, bad kinds and bad shapes included
			r = request_t'(102'({$urandom(), $urandom(), $urandom(), $urandom()}));
		end
		return r;
	endfunction

	initial begin
		dir_row_t dir_rows[$];
		dir_row_t row;
		ledger_result_t ok0;
		logic [31:0] phase_limits[4][4];
		int n;
		for (int i = 0; i < KINDS; i++) begin
			lim_q[i] = 0;
			used_q[i] = 0;
			resv_q[i] = 0;
			hwm_q[i] = 0;
			epoch_q[i] = 1;
			blk_q[i] = 0;
			exh_q[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reserve on limit 0 right after reset: block set
		ok0 = '0;
		ok0.outcome = OC_BLOCK_SET;
		ok0.epoch = 1;
		ok0.blocked = 1'b1;
		row.req = make_req(ACT_RESERVE, 0, 1, 0, 0, 1'b0);
		row.check_row = 1'b1; row.want = ok0; dir_rows.push_back(row);
		row.check_row = 1'b0;
		row.req = make_req(ACT_INVALID, 1, 0, 0, 0, 1'b0);
		row.check_row = 1'b1; row.want = err_result(ST_INVALID); dir_rows.push_back(row);
		row.req = make_req(ACT_RESERVE, 7, 5, 0, 0, 1'b0);
		dir_rows.push_back(row);
		row.req = make_req(ACT_RESERVE, 1, 0, 0, 0, 1'b0);
		dir_rows.push_back(row);
		row.req = make_req(ACT_COMMIT, 1, 3, 0, 0, 1'b1);
		dir_rows.push_back(row);
		row.req = make_req(ACT_RELEASE, 1, 1, 1, 0, 1'b0);
		dir_rows.push_back(row);
		row.req = make_req(ACT_RELEASE, 1, 0, 0, 0, 1'b1);
		dir_rows.push_back(row);
		// commit and release beyond the counts on an empty entry
		row.req = make_req(ACT_COMMIT, 2, ALL_ONES, 0, 0, 1'b0);
		row.want = err_result(ST_CORRUPT); dir_rows.push_back(row);
		row.req = make_req(ACT_RELEASE, 2, 0, ALL_ONES, ALL_ONES, 1'b0);
		dir_rows.push_back(row);
		row.check_row = 1'b0;
		// predictor-checked rows under the limits written below (0, 7, 100 and all ones)
		row.req = make_req(ACT_RESERVE, 3, ALL_ONES, 0, 0, 1'b0); dir_rows.push_back(row);
		row.req = make_req(ACT_RESERVE, 3, 1, 0, 0, 1'b0); dir_rows.push_back(row);
		row.req = make_req(ACT_COMMIT, 3, 32'h8000_0000, 0, 0, 1'b0); dir_rows.push_back(row);
		row.req = make_req(ACT_RELEASE, 3, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		dir_rows.push_back(row);
		row.req = make_req(ACT_RESERVE, 2, 10, 0, 0, 1'b0); dir_rows.push_back(row);
		row.req = make_req(ACT_RESERVE, 2, 91, 0, 0, 1'b0); dir_rows.push_back(row);
		row.req = make_req(ACT_RESERVE, 2, 91, 0, 0, 1'b0); dir_rows.push_back(row);
		row.req = make_req(ACT_RELEASE, 2, 0, 0, 5, 1'b1); dir_rows.push_back(row);
		row.req = make_req(ACT_RELEASE, 0, 0, 0, 0, 1'b0); dir_rows.push_back(row);
		row.req = make_req(ACT_RELEASE, 0, 0, 1, 0, 1'b1); dir_rows.push_back(row);

		// first rows run on reset limits
		for (int i = 0; i < 9; i++) begin
			send_request(dir_rows[i].req, 0);
			if (dir_rows[i].check_row)
				pending_results[pending_results.size() - 1] = dir_rows[i].want;
		end
		s_tvalid <= 1'b0;
		drain_results();
		apb_write(0, 32'd0);
		apb_write(1, 32'd7);
		apb_write(2, 32'd100);
		apb_write(3, ALL_ONES);
		for (int i = 9; i < dir_rows.size(); i++)
			send_request(dir_rows[i].req, $urandom_range(0, 2));
		s_tvalid <= 1'b0;
		drain_results();

		// random phases with different limit settings, extremes among them
		phase_limits = '{
			'{32'd20, 32'd1, 32'd300, 32'd64},
			'{ALL_ONES, 32'd1000, 32'd5, 32'd0},
			'{32'd3, ALL_ONES, 32'd50, 32'd100000},
			'{32'd200, 32'd40, ALL_ONES, 32'd8}};
		for (int ph = 0; ph < 4; ph++) begin
			for (int i = 0; i < KINDS; i++)
				apb_write(i, phase_limits[ph][i]);
			n = 0;
			while (n < 385) begin
				if (ph == 1 && n == 100)
					hold_long = 1'b1;
				if (ph == 2 && n == 200) begin
					s_tvalid <= 1'b0;
					while (pending_results.size() != 0) @(posedge clk);
				end
				send_request(random_request(),
					$urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14));
				n++;
			end
			s_tvalid <= 1'b0;
			drain_results();
		end

		// epoch near all ones is unreachable by counting, so the exhausted
		// paths stay with the predictor only when reached
		stim_done = 1'b1;
		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("capacity_quota_ledger_unit regression: pass");
		end else begin
			$display("capacity_quota_ledger_unit regression: fail");
		end
		$finish;
	end

endmodule
